// ----- hdl/mma_pkg.sv -----
// Shared types and constants for the matrix multiply-accumulate block
`timescale 1ns / 1ps
package mma_pkg;

    // Input word opcodes
    localparam logic [1:0] OP_LOAD_A  = 2'd0;
    localparam logic [1:0] OP_LOAD_B  = 2'd1;
    localparam logic [1:0] OP_LOAD_C  = 2'd2;
    localparam logic [1:0] OP_COMPUTE = 2'd3;

    // Configuration register indexes
    localparam logic [2:0] CFG_TRANSPOSE_A = 3'd0;
    localparam logic [2:0] CFG_TRANSPOSE_B = 3'd1;
    localparam logic [2:0] CFG_ROWS_M      = 3'd2;
    localparam logic [2:0] CFG_COLS_N      = 3'd3;
    localparam logic [2:0] CFG_INNER_K     = 3'd4;
    localparam logic [2:0] CFG_ALPHA_Q     = 3'd5;
    localparam logic [2:0] CFG_BETA_Q      = 3'd6;

    localparam logic [4:0]  DIM_RESET   = 5'd16;
    localparam logic [31:0] ALPHA_RESET = 32'h0001_0000;
    localparam logic [31:0] BETA_RESET  = 32'h0000_0000;

    localparam logic [31:0] SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] SAT_MIN = 32'h8000_0000;

    localparam int ACC_W  = 52;
    localparam int WIDE_W = 84;
    localparam int SPLIT  = 26;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_SCALE,
        ST_FINISH,
        ST_EMIT
    } ctrl_state_t;

    // What the shared multiplier is doing with the operands it is given
    typedef enum logic [2:0] {
        TAG_NONE,
        TAG_MAC,
        TAG_ALO,
        TAG_AHI,
        TAG_BC
    } mul_tag_t;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

endpackage

// ----- hdl/mma_if.sv -----
// Valid/ready channel interfaces for input and result words
`timescale 1ns / 1ps
interface mma_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         opcode;
    logic [3:0]         row;
    logic [3:0]         col;
    logic signed [31:0] value;

    modport source (output valid, output opcode, output row, output col, output value,
                    input ready);
    modport sink   (input valid, input opcode, input row, input col, input value,
                    output ready);
endinterface

interface mma_out_if;
    logic               valid;
    logic               ready;
    logic [3:0]         out_row;
    logic [3:0]         out_col;
    logic signed [31:0] out_value;
    logic               last;

    modport source (output valid, output out_row, output out_col, output out_value,
                    output last, input ready);
    modport sink   (input valid, input out_row, input out_col, input out_value,
                    input last, output ready);
endinterface

// ----- hdl/matrix_multiply_accumulate_top.sv -----
// Top level: configuration registers, stores, shared MAC unit and sequencer
//
//  channel   dir  handshake       payload
//  in_ch     in   valid/ready     opcode, row, col, value
//  out_ch    out  valid/ready     out_row, out_col, out_value, last
//  cfg       in   cfg_we          cfg_index, cfg_data
//
//  A compute word is paced by the one 33x33 multiplier: inner_k products per column,
//  then three scaling products. in_ch is not ready during a compute. A result word
//  waits in the output register; the sequencer stalls before the next column while
//  it is not taken.
//  Reset clears control and configuration; store contents are undefined until written.
`timescale 1ns / 1ps
module matrix_multiply_accumulate_top #(
    parameter int MAX_DIM = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    mma_in_if.sink      in_ch,
    mma_out_if.source   out_ch
);

    localparam logic [4:0] DIM_CAP = 5'((MAX_DIM < 16) ? MAX_DIM : 16);

    logic        transpose_a_reg;
    logic        transpose_b_reg;
    logic [4:0]  rows_m_reg;
    logic [4:0]  cols_n_reg;
    logic [4:0]  inner_k_reg;
    logic [31:0] alpha_q_reg;
    logic [31:0] beta_q_reg;

    logic [4:0] dim_m;
    logic [4:0] dim_n;
    logic [4:0] dim_k;

    logic                in_ready;
    logic                ld_we;
    mma_pkg::mul_tag_t   tag;
    mma_pkg::unit_stat_t stat;
    logic [31:0]         res;
    logic [3:0]          a_row;
    logic [3:0]          a_col;
    logic [3:0]          b_row;
    logic [3:0]          b_col;
    logic [3:0]          c_row;
    logic [3:0]          c_col;
    logic [31:0]         a_data;
    logic [31:0]         b_data;
    logic [31:0]         c_data;
    logic                wb_we;
    logic [31:0]         out_value;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            transpose_a_reg <= 1'b0;
            transpose_b_reg <= 1'b0;
            rows_m_reg      <= mma_pkg::DIM_RESET;
            cols_n_reg      <= mma_pkg::DIM_RESET;
            inner_k_reg     <= mma_pkg::DIM_RESET;
            alpha_q_reg     <= mma_pkg::ALPHA_RESET;
            beta_q_reg      <= mma_pkg::BETA_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                mma_pkg::CFG_TRANSPOSE_A: transpose_a_reg <= cfg_data[0];
                mma_pkg::CFG_TRANSPOSE_B: transpose_b_reg <= cfg_data[0];
                mma_pkg::CFG_ROWS_M:      rows_m_reg      <= cfg_data[4:0];
                mma_pkg::CFG_COLS_N:      cols_n_reg      <= cfg_data[4:0];
                mma_pkg::CFG_INNER_K:     inner_k_reg     <= cfg_data[4:0];
                mma_pkg::CFG_ALPHA_Q:     alpha_q_reg     <= cfg_data;
                mma_pkg::CFG_BETA_Q:      beta_q_reg      <= cfg_data;
                default:                  alpha_q_reg     <= alpha_q_reg;
            endcase
        end
    end

    assign dim_m = (rows_m_reg > DIM_CAP) ? DIM_CAP : rows_m_reg;
    assign dim_n = (cols_n_reg > DIM_CAP) ? DIM_CAP : cols_n_reg;
    assign dim_k = (inner_k_reg > DIM_CAP) ? DIM_CAP : inner_k_reg;

    assign in_ch.ready = in_ready;
    assign ld_we       = in_ch.valid && in_ready && in_ch.opcode != mma_pkg::OP_COMPUTE;

    mma_store #(
        .MAX_DIM (MAX_DIM)
    ) u_store (
        .clk      (clk),
        .ld_we    (ld_we),
        .ld_sel   (in_ch.opcode),
        .ld_row   (in_ch.row),
        .ld_col   (in_ch.col),
        .ld_value (in_ch.value),
        .wb_we    (wb_we),
        .wb_row   (c_row),
        .wb_col   (c_col),
        .wb_value (res),
        .a_row    (a_row),
        .a_col    (a_col),
        .b_row    (b_row),
        .b_col    (b_col),
        .c_row    (c_row),
        .c_col    (c_col),
        .a_data   (a_data),
        .b_data   (b_data),
        .c_data   (c_data)
    );

    mma_mac_unit u_unit (
        .clk    (clk),
        .rst_n  (rst_n),
        .tag_in (tag),
        .a_data (a_data),
        .b_data (b_data),
        .c_data (c_data),
        .alpha  (alpha_q_reg),
        .beta   (beta_q_reg),
        .stat   (stat),
        .res    (res)
    );

    mma_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .transpose_a (transpose_a_reg),
        .transpose_b (transpose_b_reg),
        .dim_m       (dim_m),
        .dim_n       (dim_n),
        .dim_k       (dim_k),
        .in_valid    (in_ch.valid),
        .in_opcode   (in_ch.opcode),
        .in_row      (in_ch.row),
        .in_ready    (in_ready),
        .tag_out     (tag),
        .stat        (stat),
        .res         (res),
        .a_row       (a_row),
        .a_col       (a_col),
        .b_row       (b_row),
        .b_col       (b_col),
        .c_row       (c_row),
        .c_col       (c_col),
        .wb_we       (wb_we),
        .out_valid   (out_ch.valid),
        .out_ready   (out_ch.ready),
        .out_row     (out_ch.out_row),
        .out_col     (out_ch.out_col),
        .out_value   (out_value),
        .out_last    (out_ch.last)
    );

    assign out_ch.out_value = out_value;

endmodule

// ----- hdl/mma_store.sv -----
// Element stores for A, B and C with registered reads
`timescale 1ns / 1ps
module mma_store #(
    parameter int MAX_DIM = 16
) (
    input  logic        clk,
    input  logic        ld_we,
    input  logic [1:0]  ld_sel,
    input  logic [3:0]  ld_row,
    input  logic [3:0]  ld_col,
    input  logic [31:0] ld_value,
    input  logic        wb_we,
    input  logic [3:0]  wb_row,
    input  logic [3:0]  wb_col,
    input  logic [31:0] wb_value,
    input  logic [3:0]  a_row,
    input  logic [3:0]  a_col,
    input  logic [3:0]  b_row,
    input  logic [3:0]  b_col,
    input  logic [3:0]  c_row,
    input  logic [3:0]  c_col,
    output logic [31:0] a_data,
    output logic [31:0] b_data,
    output logic [31:0] c_data
);

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam logic [6:0] DIM_L = 7'(MAX_DIM);

    logic [31:0] mem_a [DEPTH];
    logic [31:0] mem_b [DEPTH];
    logic [31:0] mem_c [DEPTH];

    logic [31:0] a_data_reg;
    logic [31:0] b_data_reg;
    logic [31:0] c_data_reg;

    logic              ld_ok;
    logic              c_we;
    logic [ADDR_W-1:0] ld_addr;
    logic [ADDR_W-1:0] c_wr_addr;
    logic [31:0]       c_wr_data;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [3:0] r, input logic [3:0] c);
        int a;
        a = int'(r) * MAX_DIM + int'(c);
        return ADDR_W'(a);
    endfunction

    assign ld_ok   = ld_we && ({3'b000, ld_row} < DIM_L) && ({3'b000, ld_col} < DIM_L);
    assign ld_addr = cell_addr(ld_row, ld_col);

    assign c_we      = wb_we || (ld_ok && ld_sel == mma_pkg::OP_LOAD_C);
    assign c_wr_addr = wb_we ? cell_addr(wb_row, wb_col) : ld_addr;
    assign c_wr_data = wb_we ? wb_value : ld_value;

    always_ff @(posedge clk)
    begin
        if (ld_ok && ld_sel == mma_pkg::OP_LOAD_A)
        begin
            mem_a[ld_addr] <= ld_value;
        end
        a_data_reg <= mem_a[cell_addr(a_row, a_col)];
    end

    always_ff @(posedge clk)
    begin
        if (ld_ok && ld_sel == mma_pkg::OP_LOAD_B)
        begin
            mem_b[ld_addr] <= ld_value;
        end
        b_data_reg <= mem_b[cell_addr(b_row, b_col)];
    end

    always_ff @(posedge clk)
    begin
        if (c_we)
        begin
            mem_c[c_wr_addr] <= c_wr_data;
        end
        c_data_reg <= mem_c[cell_addr(c_row, c_col)];
    end

    assign a_data = a_data_reg;
    assign b_data = b_data_reg;
    assign c_data = c_data_reg;

endmodule

// ----- hdl/mma_mac_unit.sv -----
// Shared 33x33 multiplier with product-sum accumulator and output scaling
`timescale 1ns / 1ps
module mma_mac_unit (
    input  logic                   clk,
    input  logic                   rst_n,
    input  mma_pkg::mul_tag_t      tag_in,
    input  logic [31:0]            a_data,
    input  logic [31:0]            b_data,
    input  logic [31:0]            c_data,
    input  logic [31:0]            alpha,
    input  logic [31:0]            beta,
    output mma_pkg::unit_stat_t    stat,
    output logic [31:0]            res
);

    localparam int ACC_W  = mma_pkg::ACC_W;
    localparam int WIDE_W = mma_pkg::WIDE_W;
    localparam int SPLIT  = mma_pkg::SPLIT;

    mma_pkg::mul_tag_t tag_d1_reg;
    mma_pkg::mul_tag_t tag_d2_reg;

    logic signed [65:0]       prod_reg;
    logic signed [65:0]       prod_next;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [WIDE_W-1:0] wide_reg;
    logic signed [WIDE_W-1:0] wide_next;
    logic [31:0]              res_reg;
    logic [31:0]              res_next;
    logic                     done_reg;
    logic                     done_next;

    logic signed [32:0]       op_a;
    logic signed [32:0]       op_b;
    logic signed [ACC_W-1:0]  mac_term;
    logic signed [WIDE_W-1:0] wide_ext;
    logic signed [68:0]       total;
    logic                     sat_hi;
    logic                     sat_lo;

    // operand select, aligned with registered store data
    always_comb
    begin
        op_a = '0;
        op_b = '0;
        case (tag_d1_reg)
            mma_pkg::TAG_MAC:
            begin
                op_a = {a_data[31], a_data};
                op_b = {b_data[31], b_data};
            end
            mma_pkg::TAG_ALO:
            begin
                op_a = {alpha[31], alpha};
                op_b = {{(33 - SPLIT){1'b0}}, acc_reg[SPLIT-1:0]};
            end
            mma_pkg::TAG_AHI:
            begin
                op_a = {alpha[31], alpha};
                op_b = {{(33 - (ACC_W - SPLIT)){acc_reg[ACC_W-1]}}, acc_reg[ACC_W-1:SPLIT]};
            end
            mma_pkg::TAG_BC:
            begin
                op_a = {beta[31], beta};
                op_b = {c_data[31], c_data};
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    assign prod_next = op_a * op_b;

    assign mac_term = {{(ACC_W - 48){prod_reg[63]}}, prod_reg[63:16]};
    assign wide_ext = {{(WIDE_W - 66){prod_reg[65]}}, prod_reg};
    assign total    = {wide_reg[WIDE_W-1], wide_reg[WIDE_W-1:16]}
                    + {{21{prod_reg[63]}}, prod_reg[63:16]};
    assign sat_hi   = !total[68] && (|total[67:31]);
    assign sat_lo   = total[68] && !(&total[67:31]);

    always_comb
    begin
        acc_next  = acc_reg;
        wide_next = wide_reg;
        res_next  = res_reg;
        done_next = 1'b0;
        case (tag_d2_reg)
            mma_pkg::TAG_MAC:
            begin
                acc_next = acc_reg + mac_term;
            end
            mma_pkg::TAG_ALO:
            begin
                wide_next = wide_ext;
            end
            mma_pkg::TAG_AHI:
            begin
                wide_next = wide_reg + (wide_ext <<< SPLIT);
            end
            mma_pkg::TAG_BC:
            begin
                if (sat_hi)
                begin
                    res_next = mma_pkg::SAT_MAX;
                end
                else if (sat_lo)
                begin
                    res_next = mma_pkg::SAT_MIN;
                end
                else
                begin
                    res_next = total[31:0];
                end
                done_next = 1'b1;
                acc_next  = '0;
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_d1_reg <= mma_pkg::TAG_NONE;
            tag_d2_reg <= mma_pkg::TAG_NONE;
            acc_reg    <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            tag_d1_reg <= tag_in;
            tag_d2_reg <= tag_d1_reg;
            acc_reg    <= acc_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        wide_reg <= wide_next;
        res_reg  <= res_next;
    end

    assign stat.busy = (tag_d1_reg != mma_pkg::TAG_NONE) || (tag_d2_reg != mma_pkg::TAG_NONE);
    assign stat.done = done_reg;
    assign res       = res_reg;

endmodule

// ----- hdl/mma_ctrl.sv -----
// Sequencer: walks columns and inner index, drives the shared unit, holds the result word
`timescale 1ns / 1ps
module mma_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 transpose_a,
    input  logic                 transpose_b,
    input  logic [4:0]           dim_m,
    input  logic [4:0]           dim_n,
    input  logic [4:0]           dim_k,
    input  logic                 in_valid,
    input  logic [1:0]           in_opcode,
    input  logic [3:0]           in_row,
    output logic                 in_ready,
    output mma_pkg::mul_tag_t    tag_out,
    input  mma_pkg::unit_stat_t  stat,
    input  logic [31:0]          res,
    output logic [3:0]           a_row,
    output logic [3:0]           a_col,
    output logic [3:0]           b_row,
    output logic [3:0]           b_col,
    output logic [3:0]           c_row,
    output logic [3:0]           c_col,
    output logic                 wb_we,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [3:0]           out_row,
    output logic [3:0]           out_col,
    output logic [31:0]          out_value,
    output logic                 out_last
);

    mma_pkg::ctrl_state_t state_reg;
    mma_pkg::ctrl_state_t state_next;

    logic [3:0]  row_reg;
    logic [3:0]  row_next;
    logic [3:0]  j_reg;
    logic [3:0]  j_next;
    logic [4:0]  q_reg;
    logic [4:0]  q_next;
    logic [1:0]  sc_reg;
    logic [1:0]  sc_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [3:0]  out_row_reg;
    logic [3:0]  out_col_reg;
    logic [31:0] out_value_reg;
    logic        out_last_reg;

    logic start;
    logic q_issue;
    logic out_free;
    logic last_col;
    logic load_out;

    assign start    = in_valid && in_opcode == mma_pkg::OP_COMPUTE
                      && ({1'b0, in_row} < dim_m) && dim_n != 5'd0;
    assign q_issue  = q_reg < dim_k;
    assign out_free = !out_valid_reg || out_ready;
    assign last_col = ({1'b0, j_reg} + 5'd1) == dim_n;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mma_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = mma_pkg::ST_MAC;
                end
            end
            mma_pkg::ST_MAC:
            begin
                if (!q_issue && !stat.busy)
                begin
                    state_next = mma_pkg::ST_SCALE;
                end
            end
            mma_pkg::ST_SCALE:
            begin
                if (sc_reg == 2'd2)
                begin
                    state_next = mma_pkg::ST_FINISH;
                end
            end
            mma_pkg::ST_FINISH:
            begin
                if (stat.done)
                begin
                    state_next = mma_pkg::ST_EMIT;
                end
            end
            mma_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = last_col ? mma_pkg::ST_IDLE : mma_pkg::ST_MAC;
                end
            end
            default:
            begin
                state_next = mma_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs and counters
    always_comb
    begin
        in_ready = 1'b0;
        tag_out  = mma_pkg::TAG_NONE;
        load_out = 1'b0;
        row_next = row_reg;
        j_next   = j_reg;
        q_next   = q_reg;
        sc_next  = 2'd0;
        unique case (state_reg)
            mma_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                row_next = in_row;
                j_next   = 4'd0;
                q_next   = 5'd0;
            end
            mma_pkg::ST_MAC:
            begin
                if (q_issue)
                begin
                    tag_out = mma_pkg::TAG_MAC;
                    q_next  = q_reg + 5'd1;
                end
            end
            mma_pkg::ST_SCALE:
            begin
                sc_next = sc_reg + 2'd1;
                case (sc_reg)
                    2'd0:    tag_out = mma_pkg::TAG_ALO;
                    2'd1:    tag_out = mma_pkg::TAG_AHI;
                    default: tag_out = mma_pkg::TAG_BC;
                endcase
            end
            mma_pkg::ST_FINISH:
            begin
                tag_out = mma_pkg::TAG_NONE;
            end
            mma_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    load_out = 1'b1;
                    j_next   = j_reg + 4'd1;
                    q_next   = 5'd0;
                end
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    assign out_valid_next = load_out ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    assign a_row = transpose_a ? q_reg[3:0] : row_reg;
    assign a_col = transpose_a ? row_reg : q_reg[3:0];
    assign b_row = transpose_b ? j_reg : q_reg[3:0];
    assign b_col = transpose_b ? q_reg[3:0] : j_reg;
    assign c_row = row_reg;
    assign c_col = j_reg;
    assign wb_we = load_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mma_pkg::ST_IDLE;
            row_reg       <= 4'd0;
            j_reg         <= 4'd0;
            q_reg         <= 5'd0;
            sc_reg        <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            row_reg       <= row_next;
            j_reg         <= j_next;
            q_reg         <= q_next;
            sc_reg        <= sc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_row_reg   <= row_reg;
            out_col_reg   <= j_reg;
            out_value_reg <= res;
            out_last_reg  <= last_col;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_row   = out_row_reg;
    assign out_col   = out_col_reg;
    assign out_value = out_value_reg;
    assign out_last  = out_last_reg;

    a_row_out_of_range: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && in_opcode == mma_pkg::OP_COMPUTE
         && ({1'b0, in_row} >= dim_m)) |=> state_reg == mma_pkg::ST_IDLE)
        else $error("compute beyond rows in use started work");

    a_last_col: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_last_reg) |-> (({1'b0, out_col_reg} + 5'd1) == dim_n))
        else $error("last mark on wrong column");

    a_scale_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mma_pkg::ST_SCALE && $past(state_reg) == mma_pkg::ST_MAC)
        |-> !stat.busy)
        else $error("scaling started before products drained");

endmodule

// ----- test/testbench.sv -----
// Self-checking testbench for the matrix multiply-accumulate block
`timescale 1ns / 1ps
module testbench;

    localparam int DIM         = 16;
    localparam int CELLS       = DIM * DIM;
    localparam int CYCLE_LIMIT = 500000;
    localparam logic signed [127:0] WIDE_MAX = 128'sd2147483647;
    localparam logic signed [127:0] WIDE_MIN = -128'sd2147483648;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [3:0]  row;
        logic [3:0]  col;
        logic [31:0] value;
    } mma_word_t;

    typedef struct packed {
        logic [3:0]  row;
        logic [3:0]  col;
        logic [31:0] value;
        logic        last;
    } c_elem_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;

    mma_in_if  in_ch ();
    mma_out_if out_ch ();

    matrix_multiply_accumulate_top #(
        .MAX_DIM (DIM)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    // Predictor state
    logic [31:0]        a_mem [CELLS];
    logic [31:0]        b_mem [CELLS];
    logic [31:0]        c_mem [CELLS];
    bit                 ta_cfg;
    bit                 tb_cfg;
    logic [4:0]         m_cfg;
    logic [4:0]         n_cfg;
    logic [4:0]         k_cfg;
    logic signed [31:0] alpha_cfg;
    logic signed [31:0] beta_cfg;

    // Which store entries the stimulus has written, indexed by load opcode
    bit loaded [3][CELLS];

    mma_word_t words_to_send [$];
    c_elem_t   c_elems_due [$];
    mma_word_t next_word;
    bit        in_fire;
    int        send_idle;
    int        recv_idle;
    int        bad;
    int        loads_seen;
    int        computes_seen;
    int        results_seen;
    int        settings_run;

    always #10 clk = ~clk;

    function automatic int dim_cap(input logic [4:0] d);
        return (d > 5'd16) ? 16 : int'(d);
    endfunction

    function automatic logic signed [127:0] scale_q(input logic signed [31:0] s,
                                                    input logic signed [127:0] x);
        logic signed [127:0] s_w;
        s_w = s;
        return (s_w * x) >>> 16;
    endfunction

    // C(r,j) = alpha*op(A)*op(B) + beta*C for one row, written back
    function automatic void gemm_row(input logic [3:0] r);
        int                  m;
        int                  n;
        int                  k;
        logic signed [31:0]  ea;
        logic signed [31:0]  eb;
        logic signed [63:0]  prod;
        logic signed [63:0]  sum;
        logic signed [127:0] total;
        logic [31:0]         res;
        c_elem_t             e;
        m = dim_cap(m_cfg);
        n = dim_cap(n_cfg);
        k = dim_cap(k_cfg);
        if (int'(r) >= m)
            return;
        for (int j = 0; j < n; j++)
        begin
            sum = 0;
            for (int q = 0; q < k; q++)
            begin
                ea   = ta_cfg ? a_mem[q * DIM + r] : a_mem[r * DIM + q];
                eb   = tb_cfg ? b_mem[j * DIM + q] : b_mem[q * DIM + j];
                prod = ea * eb;
                sum  = sum + (prod >>> 16);
            end
            total = scale_q(alpha_cfg, sum) + scale_q(beta_cfg, $signed(c_mem[r * DIM + j]));
            if (total > WIDE_MAX)
                res = mma_pkg::SAT_MAX;
            else if (total < WIDE_MIN)
                res = mma_pkg::SAT_MIN;
            else
                res = total[31:0];
            c_mem[r * DIM + j] = res;
            e.row   = r;
            e.col   = 4'(j);
            e.value = res;
            e.last  = (j == n - 1);
            c_elems_due.push_back(e);
        end
    endfunction

    function automatic void take_word();
        int idx;
        idx = in_ch.row * DIM + in_ch.col;
        case (in_ch.opcode)
            mma_pkg::OP_LOAD_A: a_mem[idx] = in_ch.value;
            mma_pkg::OP_LOAD_B: b_mem[idx] = in_ch.value;
            mma_pkg::OP_LOAD_C: c_mem[idx] = in_ch.value;
            default:            gemm_row(in_ch.row);
        endcase
        if (in_ch.opcode == mma_pkg::OP_COMPUTE)
            computes_seen++;
        else
            loads_seen++;
    endfunction

    function automatic void check_c_elem();
        c_elem_t got;
        c_elem_t want;
        got.row   = out_ch.out_row;
        got.col   = out_ch.out_col;
        got.value = out_ch.out_value;
        got.last  = out_ch.last;
        if (c_elems_due.size() == 0)
        begin
            bad++;
            if (bad <= 10)
                $display("unexpected word: row %0d col %0d value %h last %b",
                         got.row, got.col, got.value, got.last);
            return;
        end
        want = c_elems_due.pop_front();
        results_seen++;
        if (got.row !== want.row || got.col !== want.col ||
            got.value !== want.value || got.last !== want.last)
        begin
            bad++;
            if (bad <= 10)
                $display({"mismatch: expected row %0d col %0d value %h last %b, ",
                          "got row %0d col %0d value %h last %b"},
                         want.row, want.col, want.value, want.last,
                         got.row, got.col, got.value, got.last);
        end
    endfunction

    // Sample on the rising edge
    always @(posedge clk)
    begin
        in_fire = rst_n && in_ch.valid && in_ch.ready;
        if (in_fire)
            take_word();
        if (rst_n && out_ch.valid && out_ch.ready)
            check_c_elem();
    end

    // Drive on the falling edge
    always @(negedge clk)
    begin
        if (!rst_n)
            in_ch.valid <= 1'b0;
        else if (!in_ch.valid || in_fire)
        begin
            if (words_to_send.size() != 0 && $urandom_range(99) >= send_idle)
            begin
                next_word = words_to_send.pop_front();
                in_ch.valid  <= 1'b1;
                in_ch.opcode <= next_word.opcode;
                in_ch.row    <= next_word.row;
                in_ch.col    <= next_word.col;
                in_ch.value  <= next_word.value;
            end
            else
                in_ch.valid <= 1'b0;
        end
        out_ch.ready <= rst_n && ($urandom_range(99) >= recv_idle);
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("testbench: done, errors");
        $finish;
    end

    function automatic logic [31:0] rand_q();
        case ($urandom_range(7))
            0, 1:    return $urandom;
            2:
            begin
                case ($urandom_range(3))
                    0:       return mma_pkg::SAT_MAX;
                    1:       return mma_pkg::SAT_MIN;
                    2:       return 32'h0;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            default: return 32'($urandom_range(32'h0004_0000)) - 32'h0002_0000;
        endcase
    endfunction

    function automatic void push_word(input logic [1:0] op, input logic [3:0] r,
                                      input logic [3:0] c, input logic [31:0] v);
        mma_word_t w;
        w.opcode = op;
        w.row    = r;
        w.col    = c;
        w.value  = v;
        words_to_send.push_back(w);
        if (op != mma_pkg::OP_COMPUTE)
            loaded[op][r * DIM + c] = 1'b1;
    endfunction

    function automatic void need(input logic [1:0] op, input int r, input int c);
        if (!loaded[op][r * DIM + c])
            push_word(op, 4'(r), 4'(c), rand_q());
    endfunction

    // Load whatever the row reads and has not been written yet, then compute it
    function automatic void queue_row(input int r);
        int m;
        int n;
        int k;
        m = dim_cap(m_cfg);
        n = dim_cap(n_cfg);
        k = dim_cap(k_cfg);
        if (r < m)
        begin
            for (int q = 0; q < k; q++)
                need(mma_pkg::OP_LOAD_A, ta_cfg ? q : r, ta_cfg ? r : q);
            for (int j = 0; j < n; j++)
            begin
                need(mma_pkg::OP_LOAD_C, r, j);
                for (int q = 0; q < k; q++)
                    need(mma_pkg::OP_LOAD_B, tb_cfg ? j : q, tb_cfg ? q : j);
            end
        end
        push_word(mma_pkg::OP_COMPUTE, 4'(r), 4'($urandom), $urandom);
    endfunction

    task automatic drain();
        int settle;
        do
            @(posedge clk);
        while (words_to_send.size() != 0 || in_ch.valid || c_elems_due.size() != 0);
        settle = dim_cap(n_cfg) * (dim_cap(k_cfg) + 10) + 32;
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            mma_pkg::CFG_TRANSPOSE_A: ta_cfg    = data[0];
            mma_pkg::CFG_TRANSPOSE_B: tb_cfg    = data[0];
            mma_pkg::CFG_ROWS_M:      m_cfg     = data[4:0];
            mma_pkg::CFG_COLS_N:      n_cfg     = data[4:0];
            mma_pkg::CFG_INNER_K:     k_cfg     = data[4:0];
            mma_pkg::CFG_ALPHA_Q:     alpha_cfg = data;
            mma_pkg::CFG_BETA_Q:      beta_cfg  = data;
            default:                  ;
        endcase
    endtask

    task automatic configure(input bit ta, input bit tb, input int m, input int n,
                             input int k, input logic [31:0] alpha, input logic [31:0] beta,
                             input int mode);
        drain();
        case (mode)
            0:
            begin
                send_idle = 12;
                recv_idle = 75;
            end
            1:
            begin
                send_idle = 75;
                recv_idle = 12;
            end
            default:
            begin
                send_idle = 0;
                recv_idle = 0;
            end
        endcase
        write_reg(mma_pkg::CFG_TRANSPOSE_A, {31'd0, ta});
        write_reg(mma_pkg::CFG_TRANSPOSE_B, {31'd0, tb});
        write_reg(mma_pkg::CFG_ROWS_M, 32'(m));
        write_reg(mma_pkg::CFG_COLS_N, 32'(n));
        write_reg(mma_pkg::CFG_INNER_K, 32'(k));
        write_reg(mma_pkg::CFG_ALPHA_Q, alpha);
        write_reg(mma_pkg::CFG_BETA_Q, beta);
        @(negedge clk);
        cfg_we <= 1'b0;
        settings_run++;
    endtask

    task automatic run_phase(input bit ta, input bit tb, input int m, input int n,
                             input int k, input logic [31:0] alpha, input logic [31:0] beta,
                             input int words, input int mode, input bit pause);
        configure(ta, tb, m, n, k, alpha, beta, mode);
        for (int i = 0; i < words; i++)
        begin
            if (pause && i == words / 2)
                drain();
            if ($urandom_range(9) < 6)
                queue_row(($urandom_range(9) == 0) ? int'($urandom_range(15))
                                                   : int'($urandom_range(m - 1)));
            else
                push_word(2'($urandom_range(mma_pkg::OP_LOAD_C)), 4'($urandom),
                          4'($urandom), rand_q());
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = mma_pkg::CFG_TRANSPOSE_A;
        cfg_data     = 32'h0;
        in_ch.valid  = 1'b0;
        in_ch.opcode = mma_pkg::OP_LOAD_A;
        in_ch.row    = 4'd0;
        in_ch.col    = 4'd0;
        in_ch.value  = 32'sd0;
        out_ch.ready = 1'b0;
        in_fire      = 1'b0;
        send_idle    = 0;
        recv_idle    = 0;
        ta_cfg       = 1'b0;
        tb_cfg       = 1'b0;
        m_cfg        = mma_pkg::DIM_RESET;
        n_cfg        = mma_pkg::DIM_RESET;
        k_cfg        = mma_pkg::DIM_RESET;
        alpha_cfg    = mma_pkg::ALPHA_RESET;
        beta_cfg     = mma_pkg::BETA_RESET;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: saturating extremes, write-back reuse, rows beyond m
        configure(1'b0, 1'b0, 2, 2, 2, 32'h0001_0000, 32'h0001_0000, 0);
        push_word(mma_pkg::OP_LOAD_A, 4'd0, 4'd0, mma_pkg::SAT_MAX);
        push_word(mma_pkg::OP_LOAD_A, 4'd0, 4'd1, mma_pkg::SAT_MIN);
        push_word(mma_pkg::OP_LOAD_B, 4'd0, 4'd0, mma_pkg::SAT_MAX);
        push_word(mma_pkg::OP_LOAD_B, 4'd1, 4'd0, mma_pkg::SAT_MIN);
        push_word(mma_pkg::OP_LOAD_B, 4'd0, 4'd1, 32'hFFFF_FFFF);
        push_word(mma_pkg::OP_LOAD_B, 4'd1, 4'd1, 32'h0001_0000);
        push_word(mma_pkg::OP_LOAD_C, 4'd0, 4'd0, mma_pkg::SAT_MAX);
        push_word(mma_pkg::OP_LOAD_C, 4'd0, 4'd1, mma_pkg::SAT_MIN);
        queue_row(0);
        push_word(mma_pkg::OP_LOAD_A, 4'd1, 4'd0, 32'h0001_8000);
        push_word(mma_pkg::OP_LOAD_A, 4'd1, 4'd1, 32'hFFFE_0000);
        push_word(mma_pkg::OP_LOAD_C, 4'd1, 4'd0, 32'h0);
        push_word(mma_pkg::OP_LOAD_C, 4'd1, 4'd1, 32'hFFFF_8000);
        queue_row(1);
        queue_row(0);
        queue_row(2);
        queue_row(15);
        push_word(mma_pkg::OP_LOAD_C, 4'd15, 4'd15, 32'hFFFF_FFFF);
        push_word(mma_pkg::OP_LOAD_A, 4'd15, 4'd15, 32'h5555_AAAA);

        run_phase(1'b0, 1'b0, 4, 4, 4, 32'h0001_0000, 32'h0001_0000, 12, 0, 1'b0);
        run_phase(1'b1, 1'b0, 16, 3, 2, 32'h0000_8000, 32'hFFFF_0000, 12, 0, 1'b1);
        run_phase(1'b0, 1'b1, 2, 16, 1, 32'hFFFF_0000, 32'h0000_4000, 12, 0, 1'b0);
        run_phase(1'b1, 1'b1, 2, 1, 16, mma_pkg::SAT_MAX, mma_pkg::SAT_MIN, 12, 1, 1'b0);
        run_phase(1'b0, 1'b0, 1, 2, 0, mma_pkg::SAT_MIN, mma_pkg::SAT_MAX, 12, 1, 1'b1);
        run_phase(1'b1, 1'b0, 5, 5, 5, $urandom, $urandom, 12, 1, 1'b0);
        run_phase(1'b0, 1'b1, 4, 6, 3, 32'($urandom_range(32'h0003_0000)) - 32'h0001_8000,
                  32'($urandom_range(32'h0003_0000)) - 32'h0001_8000, 12, 2, 1'b1);
        run_phase(1'b1, 1'b1, 3, 20, 1, 32'h0, $urandom, 12, 2, 1'b0);
        drain();

        $display("summary: %0d load words and %0d compute words over %0d settings",
                 loads_seen, computes_seen, settings_run);
        $display("summary: %0d C elements checked, %0d mismatches", results_seen, bad);
        if (bad == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
